/* design/complex_arithmetic_unit_macros.svh */
// Assertion macros shared by the complex arithmetic unit.
// Used by complex_arithmetic_unit.sv; needs no other file.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Implication checked in the same cycle.
`define CAU_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CAU_CHECK_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cau_pkg.sv */
// Types and constants of the complex arithmetic unit.
// Used by every module of the block; depends on nothing.
package cau_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int RES_W      = SUM_W - FRAC_W + 1;
  localparam int QUO_W      = DATA_W + 1;
  localparam int OVF_SHIFT  = QUO_W - FRAC_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int ROOT_W     = DIV_STEPS;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int SQREM_W    = ROOT_W + 2;

  localparam logic signed [RES_W-1:0] POS_LIM =
      {{(RES_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] NEG_LIM = ~POS_LIM;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CONJ, OP_NEG, OP_SQMAG, OP_MAG
  } op_t;

  typedef enum logic [1:0] {
    ST_OK, ST_SAT, ST_DIVZERO
  } status_t;

  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic                     dz;
    logic signed [RES_W-1:0]  simple_re;
    logic signed [RES_W-1:0]  simple_im;
    logic [PROD_W-1:0]        den;
    logic                     neg_re;
    logic                     neg_im;
    logic                     ovf_re;
    logic                     ovf_im;
    logic [PROD_W-1:0]        rem_re;
    logic [PROD_W-1:0]        rem_im;
    logic [QUO_W-1:0]         feed_re;
    logic [QUO_W-1:0]         feed_im;
    logic [QUO_W-1:0]         quo_re;
    logic [QUO_W-1:0]         quo_im;
    logic [SQ_W-1:0]          sq_feed;
    logic [SQREM_W-1:0]       sq_rem;
    logic [ROOT_W-1:0]        sq_root;
  } stage_t;

endpackage

/* design/complex_arithmetic_unit.sv */
// Complex arithmetic unit in signed Q16.16: add, subtract, multiply, divide, conjugate,
// negate, squared magnitude and magnitude, one operation per transfer. The pipeline takes
// one transfer every cycle while the output is not stalled, and passes each result through
// four front stages (input, products, sums, divider setup), 33 one-bit steps of the long
// dividers and the square root, and the output register. A stall on the output side
// holds the whole pipeline. Depends on cau_pkg, cau_front, cau_iter, cau_back and the
// macro header.
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [4*DATA_W-1:0] s_tdata,  // a_real, a_imag, b_real, b_imag
  input  logic [2:0]          s_tuser,  // action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [2*DATA_W-1:0] m_tdata,  // out_real, out_imag
  output logic [1:0]          m_tuser   // status
);

  logic    advance;
  stage_t  chain [0:DIV_STEPS];
  status_t status;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign m_tuser  = status;

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s_tvalid),
    .in_op     (op_t'(s_tuser)),
    .in_ar     (s_tdata[DATA_W-1:0]),
    .in_ai     (s_tdata[2*DATA_W-1:DATA_W]),
    .in_br     (s_tdata[3*DATA_W-1:2*DATA_W]),
    .in_bi     (s_tdata[4*DATA_W-1:3*DATA_W]),
    .out_stage (chain[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    cau_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_stage  (chain[i]),
      .out_stage (chain[i+1])
    );
  end

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_stage  (chain[DIV_STEPS]),
    .out_valid (m_tvalid),
    .out_real  (m_tdata[DATA_W-1:0]),
    .out_imag  (m_tdata[2*DATA_W-1:DATA_W]),
    .status    (status)
  );

  `CAU_CHECK(a_divzero_zero, clk, rst, m_tvalid && m_tuser == ST_DIVZERO, m_tdata == '0, "division by zero must give a zero result")
  `CAU_CHECK(a_stall_blocks, clk, rst, m_tvalid && !m_tready, !s_tready, "input accepted while output is stalled")
  `CAU_CHECK(a_empty_accepts, clk, rst, !m_tvalid, s_tready, "input refused while output is empty")
  `CAU_CHECK_NEXT(a_reset_empty, clk, rst, !m_tvalid, "output valid right after reset")

endmodule

/* design/cau_front.sv */
// Front pipeline: input register, products, sums and divider/root setup.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  op_t               in_op,
  input  logic [DATA_W-1:0] in_ar,
  input  logic [DATA_W-1:0] in_ai,
  input  logic [DATA_W-1:0] in_br,
  input  logic [DATA_W-1:0] in_bi,
  output stage_t            out_stage
);

  logic                     s0_valid;
  op_t                      s0_op;
  logic signed [DATA_W-1:0] s0_ar, s0_ai, s0_br, s0_bi;

  logic                     s1_valid;
  op_t                      s1_op;
  logic signed [PROD_W-1:0] s1_p0, s1_p1, s1_p2, s1_p3, s1_p4, s1_p5;
  logic signed [RES_W-1:0]  s1_simple_re, s1_simple_im;

  logic                     s2_valid;
  op_t                      s2_op;
  logic signed [SUM_W-1:0]  s2_sum_re, s2_sum_im;
  logic [PROD_W-1:0]        s2_den;
  logic signed [RES_W-1:0]  s2_simple_re, s2_simple_im;

  logic signed [DATA_W-1:0] mb0, mb1;
  logic signed [PROD_W-1:0] p0_c, p1_c, p2_c, p3_c, p4_c, p5_c;
  logic signed [RES_W-1:0]  simple_re_c, simple_im_c;
  logic signed [RES_W-1:0]  ar_x, ai_x, br_x, bi_x;

  logic signed [SUM_W-1:0]  a0, a1, a2, a3;
  logic signed [SUM_W-1:0]  sum_re_c, sum_im_c;
  logic signed [RES_W-1:0]  simple2_re_c, simple2_im_c;
  logic [PROD_W-1:0]        den_c;

  logic [PROD_W-1:0]        mag_re, mag_im;
  stage_t                   stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_stage.valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid;
      s0_op    <= in_op;
      s0_ar    <= in_ar;
      s0_ai    <= in_ai;
      s0_br    <= in_br;
      s0_bi    <= in_bi;
      s1_valid <= s0_valid;
      s1_op    <= s0_op;
      s1_p0    <= p0_c;
      s1_p1    <= p1_c;
      s1_p2    <= p2_c;
      s1_p3    <= p3_c;
      s1_p4    <= p4_c;
      s1_p5    <= p5_c;
      s1_simple_re <= simple_re_c;
      s1_simple_im <= simple_im_c;
      s2_valid <= s1_valid;
      s2_op    <= s1_op;
      s2_sum_re <= sum_re_c;
      s2_sum_im <= sum_im_c;
      s2_den   <= den_c;
      s2_simple_re <= simple2_re_c;
      s2_simple_im <= simple2_im_c;
      out_stage <= stage_next;
    end
  end

  always_comb begin
    if (s0_op == OP_SQMAG || s0_op == OP_MAG) begin
      mb0 = s0_ar;
      mb1 = s0_ai;
    end else begin
      mb0 = s0_br;
      mb1 = s0_bi;
    end
    p0_c = PROD_W'(s0_ar) * PROD_W'(mb0);
    p1_c = PROD_W'(s0_ai) * PROD_W'(mb1);
    p2_c = PROD_W'(s0_ar) * PROD_W'(s0_bi);
    p3_c = PROD_W'(s0_ai) * PROD_W'(s0_br);
    p4_c = PROD_W'(s0_br) * PROD_W'(s0_br);
    p5_c = PROD_W'(s0_bi) * PROD_W'(s0_bi);
    ar_x = RES_W'(s0_ar);
    ai_x = RES_W'(s0_ai);
    br_x = RES_W'(s0_br);
    bi_x = RES_W'(s0_bi);
    case (s0_op)
      OP_ADD: begin
        simple_re_c = ar_x + br_x;
        simple_im_c = ai_x + bi_x;
      end
      OP_SUB: begin
        simple_re_c = ar_x - br_x;
        simple_im_c = ai_x - bi_x;
      end
      OP_CONJ: begin
        simple_re_c = ar_x;
        simple_im_c = -ai_x;
      end
      OP_NEG: begin
        simple_re_c = -ar_x;
        simple_im_c = -ai_x;
      end
      default: begin
        simple_re_c = '0;
        simple_im_c = '0;
      end
    endcase
  end

  always_comb begin
    a0 = SUM_W'(s1_p0);
    a1 = SUM_W'(s1_p1);
    a2 = SUM_W'(s1_p2);
    a3 = SUM_W'(s1_p3);
    den_c = $unsigned(s1_p4) + $unsigned(s1_p5);
    simple2_re_c = s1_simple_re;
    simple2_im_c = s1_simple_im;
    case (s1_op)
      OP_MUL: begin
        sum_re_c = a0 - a1;
        sum_im_c = a2 + a3;
        simple2_re_c = RES_W'(sum_re_c >>> FRAC_W);
        simple2_im_c = RES_W'(sum_im_c >>> FRAC_W);
      end
      OP_DIV: begin
        sum_re_c = a0 + a1;
        sum_im_c = a3 - a2;
      end
      OP_SQMAG: begin
        sum_re_c = a0 + a1;
        sum_im_c = '0;
        simple2_re_c = RES_W'(sum_re_c >>> FRAC_W);
        simple2_im_c = '0;
      end
      default: begin
        sum_re_c = a0 + a1;
        sum_im_c = '0;
      end
    endcase
  end

  always_comb begin
    mag_re = s2_sum_re[SUM_W-1] ? PROD_W'(-s2_sum_re) : PROD_W'(s2_sum_re);
    mag_im = s2_sum_im[SUM_W-1] ? PROD_W'(-s2_sum_im) : PROD_W'(s2_sum_im);
    stage_next.valid     = s2_valid;
    stage_next.op        = s2_op;
    stage_next.dz        = (s2_den == '0);
    stage_next.simple_re = s2_simple_re;
    stage_next.simple_im = s2_simple_im;
    stage_next.den       = s2_den;
    stage_next.neg_re    = s2_sum_re[SUM_W-1];
    stage_next.neg_im    = s2_sum_im[SUM_W-1];
    stage_next.ovf_re    = {{OVF_SHIFT{1'b0}}, mag_re} >= {s2_den, {OVF_SHIFT{1'b0}}};
    stage_next.ovf_im    = {{OVF_SHIFT{1'b0}}, mag_im} >= {s2_den, {OVF_SHIFT{1'b0}}};
    stage_next.rem_re    = mag_re >> OVF_SHIFT;
    stage_next.rem_im    = mag_im >> OVF_SHIFT;
    stage_next.feed_re   = {mag_re[OVF_SHIFT-1:0], {FRAC_W{1'b0}}};
    stage_next.feed_im   = {mag_im[OVF_SHIFT-1:0], {FRAC_W{1'b0}}};
    stage_next.quo_re    = '0;
    stage_next.quo_im    = '0;
    stage_next.sq_feed   = SQ_W'(mag_re);
    stage_next.sq_rem    = '0;
    stage_next.sq_root   = '0;
  end

endmodule

/* design/cau_iter.sv */
// One registered step of both long dividers and of the square root.
// Depends on cau_pkg.
module cau_iter import cau_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  stage_t in_stage,
  output stage_t out_stage
);

  stage_t                stage_next;
  logic [PROD_W:0]       cand_re, cand_im, den_x;
  logic [SQREM_W+1:0]    sq_cand, sq_trial;

  always_comb begin
    stage_next = in_stage;
    den_x   = {1'b0, in_stage.den};
    cand_re = {in_stage.rem_re, in_stage.feed_re[QUO_W-1]};
    cand_im = {in_stage.rem_im, in_stage.feed_im[QUO_W-1]};
    stage_next.feed_re = {in_stage.feed_re[QUO_W-2:0], 1'b0};
    stage_next.feed_im = {in_stage.feed_im[QUO_W-2:0], 1'b0};
    if (cand_re >= den_x) begin
      stage_next.rem_re = PROD_W'(cand_re - den_x);
      stage_next.quo_re = {in_stage.quo_re[QUO_W-2:0], 1'b1};
    end else begin
      stage_next.rem_re = PROD_W'(cand_re);
      stage_next.quo_re = {in_stage.quo_re[QUO_W-2:0], 1'b0};
    end
    if (cand_im >= den_x) begin
      stage_next.rem_im = PROD_W'(cand_im - den_x);
      stage_next.quo_im = {in_stage.quo_im[QUO_W-2:0], 1'b1};
    end else begin
      stage_next.rem_im = PROD_W'(cand_im);
      stage_next.quo_im = {in_stage.quo_im[QUO_W-2:0], 1'b0};
    end
    sq_cand  = {in_stage.sq_rem, in_stage.sq_feed[SQ_W-1:SQ_W-2]};
    sq_trial = (SQREM_W+2)'({in_stage.sq_root, 2'b01});
    stage_next.sq_feed = {in_stage.sq_feed[SQ_W-3:0], 2'b00};
    if (sq_cand >= sq_trial) begin
      stage_next.sq_rem  = SQREM_W'(sq_cand - sq_trial);
      stage_next.sq_root = {in_stage.sq_root[ROOT_W-2:0], 1'b1};
    end else begin
      stage_next.sq_rem  = SQREM_W'(sq_cand);
      stage_next.sq_root = {in_stage.sq_root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else if (advance) begin
      out_stage <= stage_next;
    end
  end

endmodule

/* design/cau_back.sv */
// Result selection, saturation and the output register.
// Depends on cau_pkg.
module cau_back import cau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  stage_t            in_stage,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_real,
  output logic [DATA_W-1:0] out_imag,
  output status_t           status
);

  logic signed [RES_W-1:0] val_re, val_im;
  logic [RES_W-1:0]        dmag_re, dmag_im;
  logic [DATA_W:0]         sat_re, sat_im;
  logic                    div_zero;
  status_t                 status_c;

  function automatic logic [DATA_W:0] sat_fn(input logic signed [RES_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > POS_LIM) begin
      r = {1'b1, POS_LIM[DATA_W-1:0]};
    end else if (v < NEG_LIM) begin
      r = {1'b1, NEG_LIM[DATA_W-1:0]};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    dmag_re = in_stage.ovf_re ? (RES_W'(1) << QUO_W) : RES_W'(in_stage.quo_re);
    dmag_im = in_stage.ovf_im ? (RES_W'(1) << QUO_W) : RES_W'(in_stage.quo_im);
    div_zero = 1'b0;
    case (in_stage.op)
      OP_DIV: begin
        div_zero = in_stage.dz;
        val_re = in_stage.neg_re ? -$signed(dmag_re) : $signed(dmag_re);
        val_im = in_stage.neg_im ? -$signed(dmag_im) : $signed(dmag_im);
        if (in_stage.dz) begin
          val_re = '0;
          val_im = '0;
        end
      end
      OP_MAG: begin
        val_re = {{(RES_W-ROOT_W){1'b0}}, in_stage.sq_root};
        val_im = '0;
      end
      default: begin
        val_re = in_stage.simple_re;
        val_im = in_stage.simple_im;
      end
    endcase
    sat_re = sat_fn(val_re);
    sat_im = sat_fn(val_im);
    if (div_zero) begin
      status_c = ST_DIVZERO;
    end else if (sat_re[DATA_W] || sat_im[DATA_W]) begin
      status_c = ST_SAT;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_stage.valid;
      out_real  <= sat_re[DATA_W-1:0];
      out_imag  <= sat_im[DATA_W-1:0];
      status    <= status_c;
    end
  end

endmodule
